// File: rtl/core/sdbp_pkg.sv
// ----------------------------------------------------------------------------
// sdbp_pkg
// shared types and codes for the step/dir backlash positioner
// ----------------------------------------------------------------------------
package sdbp_pkg;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_SET_TARGET = 2'd1,
        REQ_RESET_POS  = 2'd2,
        REQ_SET_INSTR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLASH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_EN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_INVERT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_HIGH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUARE      = 3'd4;

    typedef struct packed {
        logic [15:0] backlash_amount;
        logic        sync_enable;
        logic        dir_invert;
        logic        step_active_high;
        logic        square_wave;
    } cfg_t;

    typedef struct packed {
        logic [31:0] motor_count;
        logic [31:0] target_count;
        logic [31:0] index_offset;
        logic [15:0] slack_count;
        logic        slack_flag;
        dir_t        move_dir;
        logic        step_phase;
        logic        dir_pin_state;
        logic        step_asserted;
    } axis_state_t;

    typedef struct packed {
        logic               step_level;
        logic               dir_level;
        logic        [1:0]  motion_dir;
        logic               taking_backlash;
        logic signed [31:0] motor_position;
        logic signed [31:0] instrument_position;
        logic signed [31:0] distance_to_target;
    } result_t;

endpackage

// File: rtl/core/sdbp_axis_update.sv
// ----------------------------------------------------------------------------
// sdbp_axis_update
// next axis state and result word for one request
// ----------------------------------------------------------------------------
module sdbp_axis_update (
    input  sdbp_pkg::axis_state_t state,
    input  sdbp_pkg::cfg_t        cfg,
    input  sdbp_pkg::req_t        req,
    input  logic [31:0]           val,
    input  logic [1:0]            sd,
    output sdbp_pkg::axis_state_t state_next,
    output sdbp_pkg::result_t     result
);
    import sdbp_pkg::*;

    logic [31:0] sync_add;
    logic [31:0] tgt_sync;
    dir_t        dec_dir;
    logic        dec_pin;
    dir_t        step_dir;
    logic        step_phase_tick;
    logic [31:0] mot_step;
    logic [15:0] slack_step;
    logic        flag_step;

    // tracking step, pattern 10 taken as minus two
    assign sync_add = {{30{sd[1]}}, sd};
    assign tgt_sync = (cfg.sync_enable && !state.slack_flag) ?
                      state.target_count + sync_add : state.target_count;

    always_comb
    begin
        dec_dir = DIR_IDLE;
        dec_pin = state.dir_pin_state;
        if ($signed(tgt_sync) < $signed(state.motor_count))
        begin
            dec_dir = DIR_REV;
            dec_pin = 1'b1;
        end
        else if (($signed(state.motor_count) < $signed(tgt_sync)) || state.slack_flag)
        begin
            dec_dir = DIR_FWD;
            dec_pin = 1'b0;
        end
    end

    assign step_phase_tick = cfg.square_wave && state.step_phase;
    assign step_dir        = step_phase_tick ? state.move_dir : dec_dir;

    // slack is filled or drained before the motor count moves
    always_comb
    begin
        mot_step   = state.motor_count;
        slack_step = state.slack_count;
        flag_step  = state.slack_flag;
        case (step_dir)
            DIR_FWD:
            begin
                if (state.slack_count < cfg.backlash_amount)
                begin
                    flag_step  = 1'b1;
                    slack_step = state.slack_count + 16'd1;
                end
                else
                begin
                    flag_step = 1'b0;
                    mot_step  = state.motor_count + 32'd1;
                end
            end
            DIR_REV:
            begin
                if (state.slack_count != 16'd0)
                begin
                    flag_step  = 1'b1;
                    slack_step = state.slack_count - 16'd1;
                end
                else
                begin
                    flag_step = 1'b0;
                    mot_step  = state.motor_count - 32'd1;
                end
            end
            default:
            begin
                mot_step = state.motor_count;
            end
        endcase
    end

    always_comb
    begin
        state_next = state;
        case (req)
            REQ_TICK:
            begin
                if (step_phase_tick)
                begin
                    state_next.step_phase  = 1'b0;
                    state_next.motor_count = mot_step;
                    state_next.slack_count = slack_step;
                    state_next.slack_flag  = flag_step;
                    if (step_dir != DIR_IDLE)
                    begin
                        state_next.step_asserted = 1'b1;
                    end
                end
                else if (cfg.square_wave)
                begin
                    state_next.step_phase    = 1'b1;
                    state_next.target_count  = tgt_sync;
                    state_next.move_dir      = dec_dir;
                    state_next.dir_pin_state = dec_pin;
                    state_next.step_asserted = 1'b0;
                end
                else
                begin
                    state_next.target_count  = tgt_sync;
                    state_next.move_dir      = dec_dir;
                    state_next.dir_pin_state = dec_pin;
                    state_next.motor_count   = mot_step;
                    state_next.slack_count   = slack_step;
                    state_next.slack_flag    = flag_step;
                    state_next.step_asserted = (dec_dir != DIR_IDLE);
                end
            end
            REQ_SET_TARGET:
            begin
                state_next.target_count = val - state.index_offset;
            end
            REQ_RESET_POS:
            begin
                state_next.index_offset = 32'd0;
                state_next.motor_count  = val;
                state_next.target_count = val;
                state_next.slack_count  = 16'd0;
            end
            default:
            begin
                state_next.index_offset = val - state.motor_count;
            end
        endcase
    end

    always_comb
    begin
        result.step_level          = state_next.step_asserted ~^ cfg.step_active_high;
        result.dir_level           = state_next.dir_pin_state ^ cfg.dir_invert;
        result.motion_dir          = state_next.move_dir;
        result.taking_backlash     = state_next.slack_flag;
        result.motor_position      = $signed(state_next.motor_count
                                     + {16'd0, state_next.slack_count});
        result.instrument_position = $signed(state_next.motor_count
                                     + state_next.index_offset);
        result.distance_to_target  = $signed(state_next.target_count
                                     - state_next.motor_count);
    end

endmodule

// File: rtl/core/sdbp_out_fifo.sv
// ----------------------------------------------------------------------------
// sdbp_out_fifo
// two-word result buffer between the update stage and the output channel
// ----------------------------------------------------------------------------
module sdbp_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  sdbp_pkg::result_t   wr_data,
    input  logic                rd_ready,
    output logic                rd_valid,
    output sdbp_pkg::result_t   rd_data,
    output logic [1:0]          count
);
    import sdbp_pkg::*;

    result_t    entry_reg [2];
    logic       head_reg;
    logic       head_next;
    logic       tail_reg;
    logic       tail_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[head_reg];
    assign count    = count_reg;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = wr_en ? ~tail_reg : tail_reg;
        count_next = count_reg + {1'b0, wr_en} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/step_dir_backlash_positioner_core.sv
// ----------------------------------------------------------------------------
// step_dir_backlash_positioner_core
// step/direction generator for one stepper axis with backlash take-up
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (req_type, value, sync_dir); each one
// yields exactly one result word on the out channel carrying the pin levels,
// motion direction, backlash flag and the three position readbacks.
// Configuration registers are written on the cfg channel (cfg_index,
// cfg_data), which is always ready; write only while the block is idle.
// A request is captured in an input register, the axis update runs in the
// next cycle and writes the result into a two-word output buffer; out_valid
// comes from that buffer, so a result passes the input register and the
// buffer before the earliest out accept.
// Throughput is one request per cycle, set by the combinational axis update,
// while the receiver keeps up; when it stalls the buffer absorbs up to two
// words in flight, and in_ready drops once the input register and buffer
// together hold two and no word leaves in that cycle.
// Reset clears positions, target, offset and slack, selects the clear phase,
// the idle direction, a forward direction pin and a deasserted step pin,
// restores register defaults (step pin active high) and empties the buffer.
// ----------------------------------------------------------------------------
module step_dir_backlash_positioner_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           req_type,
    input  logic signed [31:0]                   value,
    input  logic signed [1:0]                    sync_dir,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 step_level,
    output logic                                 dir_level,
    output logic [1:0]                           motion_dir,
    output logic                                 taking_backlash,
    output logic signed [31:0]                   motor_position,
    output logic signed [31:0]                   instrument_position,
    output logic signed [31:0]                   distance_to_target,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sdbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sdbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sdbp_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    axis_state_t state_reg;
    axis_state_t state_next;
    result_t     upd_result;
    result_t     head_word;

    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic [31:0] s1_val_reg;
    logic [1:0]  s1_sd_reg;

    logic [1:0]  fifo_count;
    logic [2:0]  occupancy;
    logic        pop;
    logic        in_accept;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BACKLASH:    cfg_next.backlash_amount  = cfg_data;
                CFG_SYNC_EN:     cfg_next.sync_enable      = cfg_data[0];
                CFG_DIR_INVERT:  cfg_next.dir_invert       = cfg_data[0];
                CFG_STEP_HIGH:   cfg_next.step_active_high = cfg_data[0];
                CFG_SQUARE:      cfg_next.square_wave      = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    assign occupancy = {1'b0, fifo_count} + {2'b00, s1_valid_reg};
    assign pop       = out_valid && out_ready;
    assign in_ready  = (occupancy < 3'd2) || ((occupancy == 3'd2) && pop);
    assign in_accept = in_valid && in_ready;

    sdbp_axis_update u_update (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (s1_req_reg),
        .val        (s1_val_reg),
        .sd         (s1_sd_reg),
        .state_next (state_next),
        .result     (upd_result)
    );

    sdbp_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s1_valid_reg),
        .wr_data  (upd_result),
        .rd_ready (out_ready),
        .rd_valid (out_valid),
        .rd_data  (head_word),
        .count    (fifo_count)
    );

    assign step_level          = head_word.step_level;
    assign dir_level           = head_word.dir_level;
    assign motion_dir          = head_word.motion_dir;
    assign taking_backlash     = head_word.taking_backlash;
    assign motor_position      = head_word.motor_position;
    assign instrument_position = head_word.instrument_position;
    assign distance_to_target  = head_word.distance_to_target;

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg <= req_t'(req_type);
            s1_val_reg <= value;
            s1_sd_reg  <= sync_dir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cfg_reg      <= '{backlash_amount: 16'd0, sync_enable: 1'b0,
                              dir_invert: 1'b0, step_active_high: 1'b1,
                              square_wave: 1'b0};
            state_reg    <= '{motor_count: 32'd0, target_count: 32'd0,
                              index_offset: 32'd0, slack_count: 16'd0,
                              slack_flag: 1'b0, move_dir: DIR_IDLE,
                              step_phase: 1'b0, dir_pin_state: 1'b0,
                              step_asserted: 1'b0};
        end
        else
        begin
            s1_valid_reg <= in_accept;
            cfg_reg      <= cfg_next;
            if (s1_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // words in flight never exceed the buffer depth
    assert property (@(posedge clk) disable iff (!rst_n) occupancy <= 3'd2)
        else $error("result buffer overrun");

    // a full pipe with no pop must stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (occupancy == 3'd2) && !pop |-> !in_ready)
        else $error("input accepted with no room");

    // non-tick requests leave the step pin and phase alone
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_req_reg != REQ_TICK) |=>
        (state_reg.step_asserted == $past(state_reg.step_asserted)) &&
        (state_reg.step_phase == $past(state_reg.step_phase)))
        else $error("non-tick request changed step pin");

    // pulse mode never toggles the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !cfg_reg.square_wave |=>
        (state_reg.step_phase == $past(state_reg.step_phase)))
        else $error("phase moved in pulse mode");

    // every processed request lands in the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !pop |=> fifo_count == $past(fifo_count) + 2'd1)
        else $error("result word lost");

endmodule

// File: test/step_dir_backlash_positioner_core_tb.sv
// ----------------------------------------------------------------------------
// step_dir_backlash_positioner_core_tb
// randomized regression for the step/dir backlash positioner
// ----------------------------------------------------------------------------
// A driver feeds request words from a pending queue and a monitor checks each
// result word against a cycle-free model of the axis that runs when a request
// is accepted. The run starts with a short hand-written sequence and then goes
// through several register settings. Each setting gets random move sequences:
// a reset position, a target near it and a burst of ticks, with some noise
// mixed in. Both sides insert random gaps, the receiver holds off for long
// stretches twice, and registers change only after the axis has drained.
// ----------------------------------------------------------------------------
module step_dir_backlash_positioner_core_tb;
    import sdbp_pkg::*;

    typedef struct packed {
        req_t        req;
        logic [31:0] val;
        logic [1:0]  sd;
    } axis_req_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             req_type;
    logic signed [31:0]     value;
    logic signed [1:0]      sync_dir;
    logic                   out_valid;
    logic                   out_ready;
    logic                   step_level;
    logic                   dir_level;
    logic [1:0]             motion_dir;
    logic                   taking_backlash;
    logic signed [31:0]     motor_position;
    logic signed [31:0]     instrument_position;
    logic signed [31:0]     distance_to_target;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    axis_req_t   pend_q[$];
    result_t     want_q[$];
    cfg_t        cfg_sh;
    logic [31:0] motor_c;
    logic [31:0] target_c;
    logic [31:0] offset_c;
    logic [15:0] slack_c;
    logic        slack_on;
    logic        phase_on;
    logic        dir_pin;
    logic        step_on;
    dir_t        mdir;

    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned accepted_cnt;
    int unsigned owed;
    int unsigned fails;
    logic        calm;
    logic        long_hold;
    logic [31:0] anchor;
    axis_req_t   sent_item;
    axis_req_t   next_item;
    logic        next_valid;
    result_t     got_exp;

    step_dir_backlash_positioner_core DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .req_type            (req_type),
        .value               (value),
        .sync_dir            (sync_dir),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .step_level          (step_level),
        .dir_level           (dir_level),
        .motion_dir          (motion_dir),
        .taking_backlash     (taking_backlash),
        .motor_position      (motor_position),
        .instrument_position (instrument_position),
        .distance_to_target  (distance_to_target),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sync then choose direction
    function automatic void plan_motion(logic [1:0] sd);
        if (cfg_sh.sync_enable && !slack_on)
            target_c = target_c + {{30{sd[1]}}, sd};
        if ($signed(target_c) < $signed(motor_c))
        begin
            mdir    = DIR_REV;
            dir_pin = 1'b1;
        end
        else if ($signed(motor_c) < $signed(target_c) || slack_on)
        begin
            mdir    = DIR_FWD;
            dir_pin = 1'b0;
        end
        else
            mdir = DIR_IDLE;
    endfunction

    function automatic void apply_step();
        if (mdir == DIR_FWD)
        begin
            if (slack_c < cfg_sh.backlash_amount)
            begin
                slack_on = 1'b1;
                slack_c  = slack_c + 16'd1;
            end
            else
            begin
                slack_on = 1'b0;
                motor_c  = motor_c + 32'd1;
            end
            step_on = 1'b1;
        end
        else if (mdir == DIR_REV)
        begin
            if (slack_c > 16'd0)
            begin
                slack_on = 1'b1;
                slack_c  = slack_c - 16'd1;
            end
            else
            begin
                slack_on = 1'b0;
                motor_c  = motor_c - 32'd1;
            end
            step_on = 1'b1;
        end
    endfunction

    function automatic result_t advance_axis(axis_req_t rq);
        result_t r;
        case (rq.req)
            REQ_TICK:
            begin
                if (cfg_sh.square_wave)
                begin
                    if (phase_on)
                    begin
                        phase_on = 1'b0;
                        apply_step();
                    end
                    else
                    begin
                        phase_on = 1'b1;
                        plan_motion(rq.sd);
                        step_on = 1'b0;
                    end
                end
                else
                begin
                    step_on = 1'b0;
                    plan_motion(rq.sd);
                    apply_step();
                end
            end
            REQ_SET_TARGET: target_c = rq.val - offset_c;
            REQ_RESET_POS:
            begin
                offset_c = 32'd0;
                motor_c  = rq.val;
                target_c = rq.val;
                slack_c  = 16'd0;
            end
            REQ_SET_INSTR: offset_c = rq.val - motor_c;
            default: ;
        endcase
        r.step_level          = step_on ? cfg_sh.step_active_high : ~cfg_sh.step_active_high;
        r.dir_level           = dir_pin ^ cfg_sh.dir_invert;
        r.motion_dir          = mdir;
        r.taking_backlash     = slack_on;
        r.motor_position      = motor_c + {16'd0, slack_c};
        r.instrument_position = motor_c + offset_c;
        r.distance_to_target  = target_c - motor_c;
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            $error("%s expected %0h actual %0h", name, e, a);
            fails++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                sent_item.req = req_t'(req_type);
                sent_item.val = value;
                sent_item.sd  = sync_dir;
                want_q.push_back(advance_axis(sent_item));
                accepted_cnt++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pend_q.size() > 0)
                begin
                    next_item = pend_q.pop_front();
                    owed++;
                    req_type   <= next_item.req;
                    value      <= next_item.val;
                    sync_dir   <= next_item.sd;
                    next_valid = 1'b1;
                    in_gap     = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (want_q.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fails++;
                end
                else
                begin
                    got_exp = want_q.pop_front();
                    cmp_field("step_level", 32'(got_exp.step_level), 32'(step_level));
                    cmp_field("dir_level", 32'(got_exp.dir_level), 32'(dir_level));
                    cmp_field("motion_dir", 32'(got_exp.motion_dir), 32'(motion_dir));
                    cmp_field("taking_backlash", 32'(got_exp.taking_backlash),
                              32'(taking_backlash));
                    cmp_field("motor_position", got_exp.motor_position, motor_position);
                    cmp_field("instrument_position", got_exp.instrument_position,
                              instrument_position);
                    cmp_field("distance_to_target", got_exp.distance_to_target,
                              distance_to_target);
                end
                if (owed > 0)
                    owed--;
            end
            if (long_hold)
                out_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    // long receiver hold-offs while requests keep coming
    initial
    begin
        while (accepted_cnt < 250)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
        while (accepted_cnt < 650)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (150) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void push_item(req_t rq, logic [31:0] v, logic [1:0] sd);
        pend_q.push_back('{rq, v, sd});
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BACKLASH:    cfg_sh.backlash_amount  = data;
            CFG_SYNC_EN:     cfg_sh.sync_enable      = data[0];
            CFG_DIR_INVERT:  cfg_sh.dir_invert       = data[0];
            CFG_STEP_HIGH:   cfg_sh.step_active_high = data[0];
            CFG_SQUARE:      cfg_sh.square_wave      = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(logic [15:0] bl, logic se, logic rv, logic hi, logic sq);
        logic [15:0] junk;
        write_reg(CFG_BACKLASH, bl);
        junk = 16'($urandom);
        write_reg(CFG_SYNC_EN, {junk[15:1], se});
        junk = 16'($urandom);
        write_reg(CFG_DIR_INVERT, {junk[15:1], rv});
        junk = 16'($urandom);
        write_reg(CFG_STEP_HIGH, {junk[15:1], hi});
        junk = 16'($urandom);
        write_reg(CFG_SQUARE, {junk[15:1], sq});
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // move sequences around an anchor, with some noise
    task automatic queue_motion(int n);
        int          k;
        int unsigned r;
        int unsigned c;
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                c = $urandom_range(0, 99);
                if (c < 20)
                    anchor = 32'h7fff_fff0 + $urandom_range(0, 15);
                else if (c < 40)
                    anchor = 32'h8000_0000 + $urandom_range(0, 15);
                else if (c < 50)
                    anchor = 32'd0;
                else
                    anchor = $urandom;
                push_item(REQ_RESET_POS, anchor, 2'($urandom_range(0, 3)));
                k++;
            end
            else if (r < 40)
            begin
                push_item(REQ_SET_TARGET, anchor + $urandom_range(0, 60) - 32'd30,
                          2'($urandom_range(0, 3)));
                k++;
                c = $urandom_range(1, 30);
                repeat (c)
                begin
                    push_item(REQ_TICK, $urandom, 2'($urandom_range(0, 3)));
                    k++;
                end
            end
            else if (r < 44)
            begin
                push_item(REQ_SET_INSTR, anchor + $urandom_range(0, 40) - 32'd20,
                          2'($urandom_range(0, 3)));
                k++;
            end
            else if (r < 46)
            begin
                push_item(REQ_SET_INSTR, $urandom, 2'($urandom_range(0, 3)));
                k++;
            end
            else if (r < 48)
            begin
                push_item(REQ_SET_TARGET, $urandom, 2'($urandom_range(0, 3)));
                k++;
            end
            else
            begin
                push_item(REQ_TICK, $urandom, 2'($urandom_range(0, 3)));
                k++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_TICK;
        value        = '0;
        sync_dir     = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        long_hold    = 1'b0;
        in_gap       = 0;
        out_gap      = 0;
        accepted_cnt = 0;
        owed         = 0;
        fails        = 0;
        anchor       = 32'd0;
        cfg_sh       = '{16'd0, 1'b0, 1'b0, 1'b1, 1'b0};
        motor_c      = 32'd0;
        target_c     = 32'd0;
        offset_c     = 32'd0;
        slack_c      = 16'd0;
        slack_on     = 1'b0;
        phase_on     = 1'b0;
        dir_pin      = 1'b0;
        step_on      = 1'b0;
        mdir         = DIR_IDLE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // idle tick, short moves, signed compare across the wrap, sync patterns
        push_item(REQ_TICK, 32'hffff_ffff, 2'b11);
        push_item(REQ_SET_TARGET, 32'd3, 2'b00);
        repeat (4) push_item(REQ_TICK, 32'd0, 2'b01);
        push_item(REQ_SET_TARGET, 32'hffff_fffe, 2'b10);
        repeat (3) push_item(REQ_TICK, 32'hffff_ffff, 2'b00);
        push_item(REQ_SET_INSTR, 32'h7fff_ffff, 2'b00);
        push_item(REQ_SET_INSTR, 32'h8000_0000, 2'b11);
        push_item(REQ_RESET_POS, 32'h7fff_ffff, 2'b01);
        push_item(REQ_SET_TARGET, 32'h8000_0000, 2'b10);
        repeat (2) push_item(REQ_TICK, 32'd0, 2'b00);
        push_item(REQ_RESET_POS, 32'h8000_0000, 2'b00);
        push_item(REQ_SET_TARGET, 32'h7fff_ffff, 2'b00);
        push_item(REQ_TICK, 32'd0, 2'b11);
        push_item(REQ_RESET_POS, 32'hffff_ffff, 2'b00);
        push_item(REQ_TICK, 32'd0, 2'b00);
        push_item(REQ_TICK, 32'd0, 2'b01);
        push_item(REQ_TICK, 32'd0, 2'b10);
        push_item(REQ_TICK, 32'd0, 2'b11);
        wait_idle();

        set_mode(16'd4, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_motion(150);
        wait_idle();

        set_mode(16'd12, 1'b0, 1'b1, 1'b0, 1'b1);
        calm <= 1'b1;
        queue_motion(150);
        wait_idle();
        calm <= 1'b0;

        // backlash below the slack already taken up
        set_mode(16'd2, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_motion(150);
        wait_idle();

        set_mode(16'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_motion(150);
        wait_idle();

        set_mode(16'hffff, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_motion(120);
        wait_idle();

        // unmapped indexes
        write_reg(3'd5, 16'($urandom));
        write_reg(3'd6, 16'($urandom));
        write_reg(3'd7, 16'($urandom));
        set_mode(16'd7, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_motion(150);
        wait_idle();

        repeat (10) @(posedge clk);
        if (want_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", want_q.size());
            fails++;
        end
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
